>>> hw/rtl/pptr_pkg.sv
// Package for the parallel-port transfer peripheral.
// Holds the request and response payload types, phase codes, kind and operation codes.
// It has no dependencies.
package pptr_pkg;

   localparam int COUNT_BITS = 16;
   localparam int LEFT_BITS  = 18;

   localparam logic [7:0] IDLE_COMMAND = 8'hff;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_START  = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;
   localparam logic [1:0] KIND_LOWER  = 2'd3;

   localparam logic [2:0] OP_RD_WORD  = 3'd0;
   localparam logic [2:0] OP_WR_WORD  = 3'd1;
   localparam logic [2:0] OP_RD_LONG  = 3'd2;
   localparam logic [2:0] OP_WR_LONG  = 3'd3;
   localparam logic [2:0] OP_RD_BLOCK = 3'd4;
   localparam logic [2:0] OP_WR_BLOCK = 3'd5;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WAIT_HI,
      PH_SEND,
      PH_RELEASE,
      PH_RECV,
      PH_END_WAIT
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  op;
      logic [15:0] word_count;
      logic [31:0] load_value;
      logic        select_level;
      logic [7:0]  bus_in;
      logic [7:0]  next_byte;
   } req_type;

   typedef struct packed {
      logic        ready_line;
      logic        drive_enable;
      logic [7:0]  bus_out;
      logic        byte_captured;
      logic [7:0]  captured_byte;
      logic        byte_consumed;
      logic [31:0] word_result;
      logic [7:0]  command;
      logic        done_res;
   } rsp_type;

endpackage

>>> hw/rtl/pptr_core.sv
// Transfer state and single-pass step logic of the parallel-port peripheral.
// Holds the phase, byte counter and shift register; depends on pptr_pkg.
module pptr_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  pptr_pkg::req_type item,
   output pptr_pkg::rsp_type result
);
   import pptr_pkg::*;

   localparam logic [15:0] COUNT_MASK = 16'((64'd1 << COUNT_BITS) - 64'd1);

   phase_type              phase_ff, phase_in;
   logic                   wanted_ff, wanted_in;
   logic [LEFT_BITS-1:0]   left_ff, left_in;
   logic [31:0]            shift_ff, shift_in;
   logic [2:0]             op_ff, op_in;
   logic                   ready_ff, ready_in;
   logic                   drive_ff, drive_in;
   logic [7:0]             out_ff, out_in;

   logic [15:0]            count;
   logic [LEFT_BITS-1:0]   start_left;
   logic [LEFT_BITS-1:0]   left_dec;
   logic [31:0]            recv_shift;

   assign count      = item.word_count & COUNT_MASK;
   assign left_dec   = left_ff - LEFT_BITS'(1);
   assign recv_shift = {shift_ff[23:0], item.bus_in};

   always_comb begin
      if (item.op == OP_RD_WORD || item.op == OP_WR_WORD) begin
         start_left = LEFT_BITS'(2);
      end else if (item.op == OP_RD_LONG || item.op == OP_WR_LONG) begin
         start_left = LEFT_BITS'(4);
      end else begin
         start_left = LEFT_BITS'({count, 1'b0});
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      wanted_in = wanted_ff;
      left_in   = left_ff;
      shift_in  = shift_ff;
      op_in     = op_ff;
      ready_in  = ready_ff;
      drive_in  = drive_ff;
      out_in    = out_ff;
      result    = '0;
      result.command = IDLE_COMMAND;

      unique case (item.kind)
         KIND_LOWER: begin
            ready_in = 1'b0;
         end
         KIND_START: begin
            if (phase_ff == PH_IDLE && item.op <= OP_WR_BLOCK) begin
               op_in    = item.op;
               ready_in = 1'b0;
               left_in  = start_left;
               if (!item.op[0]) begin
                  // Left-align so that the top byte leaves first.
                  shift_in = (item.op == OP_RD_WORD) ? {item.load_value[15:0], 16'h0000}
                                                     : item.load_value;
                  phase_in = PH_WAIT_HI;
               end else begin
                  shift_in  = '0;
                  wanted_in = 1'b1;
                  if (start_left == '0) begin
                     phase_in        = PH_IDLE;
                     result.done_res = 1'b1;
                  end else begin
                     phase_in = PH_RECV;
                  end
               end
            end
         end
         KIND_END: begin
            if (phase_ff == PH_IDLE || phase_ff == PH_END_WAIT) begin
               if (item.select_level) begin
                  ready_in = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_END_WAIT;
               end
            end
         end
         default: begin
            unique case (phase_ff)
               PH_IDLE: begin
                  if (!item.select_level) begin
                     result.command = item.bus_in;
                  end
               end
               PH_WAIT_HI: begin
                  if (item.select_level) begin
                     drive_in  = 1'b1;
                     wanted_in = 1'b0;
                     phase_in  = (left_ff != '0) ? PH_SEND : PH_RELEASE;
                  end
               end
               PH_SEND: begin
                  if (item.select_level == wanted_ff) begin
                     if (op_ff == OP_RD_BLOCK) begin
                        out_in               = item.next_byte;
                        result.byte_consumed = 1'b1;
                     end else begin
                        out_in   = shift_ff[31:24];
                        shift_in = {shift_ff[23:0], 8'h00};
                     end
                     wanted_in = ~wanted_ff;
                     left_in   = left_dec;
                     if (left_dec == '0) begin
                        phase_in = PH_RELEASE;
                     end
                  end
               end
               PH_RELEASE: begin
                  if (!item.select_level) begin
                     drive_in        = 1'b0;
                     phase_in        = PH_IDLE;
                     result.done_res = 1'b1;
                  end
               end
               PH_RECV: begin
                  if (item.select_level == wanted_ff) begin
                     result.byte_captured = 1'b1;
                     result.captured_byte = item.bus_in;
                     shift_in             = recv_shift;
                     wanted_in            = ~wanted_ff;
                     left_in              = left_dec;
                     if (left_dec == '0) begin
                        phase_in        = PH_IDLE;
                        result.done_res = 1'b1;
                        if (op_ff != OP_WR_BLOCK) begin
                           result.word_result = recv_shift;
                        end
                     end
                  end
               end
               PH_END_WAIT: begin
                  if (item.select_level) begin
                     ready_in = 1'b1;
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      endcase

      result.ready_line   = ready_in;
      result.drive_enable = drive_in;
      result.bus_out      = out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         wanted_ff <= 1'b1;
         left_ff   <= '0;
         shift_ff  <= '0;
         op_ff     <= '0;
         ready_ff  <= 1'b1;
         drive_ff  <= 1'b0;
         out_ff    <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         wanted_ff <= wanted_in;
         left_ff   <= left_in;
         shift_ff  <= shift_in;
         op_ff     <= op_in;
         ready_ff  <= ready_in;
         drive_ff  <= drive_in;
         out_ff    <= out_in;
      end
   end

`ifndef NO_ASSERTIONS
   // The bus is driven exactly while bytes are going out or waiting for release.
   a_drive_phase: assert property (@(posedge clock) disable iff (reset)
      drive_ff == (phase_ff == PH_SEND || phase_ff == PH_RELEASE))
      else $error("bus drive does not match the transfer phase");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_WAIT_HI || phase_ff == PH_SEND || phase_ff == PH_RELEASE ||
       phase_ff == PH_RECV) |-> !ready_ff)
      else $error("ready is high during a running transfer");

   a_send_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SEND || phase_ff == PH_RECV) |-> left_ff != '0)
      else $error("byte phase entered with no bytes left");

   a_done_leaves_busy: assert property (@(posedge clock) disable iff (reset)
      (fire && result.done_res) |=> phase_ff == PH_IDLE)
      else $error("completed transfer did not return to idle");
`endif

endmodule

>>> hw/rtl/parallel_port_ddr_transfer_slave.sv
// Top level of the parallel-port transfer peripheral.
// Wraps pptr_core with the request input register and the response register; uses pptr_pkg.
//
// One request is taken every clock cycle unless the response stalls, and each gives exactly
// one response: the request is registered, stepped through the transfer logic in a single
// pass and the response registered. The rate is set by that single-pass step, which updates
// the transfer state once per request; a stalled response holds the request register and
// back-pressures the request channel.
module parallel_port_ddr_transfer_slave (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pptr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pptr_pkg::rsp_type rsp_data
);
   import pptr_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   rsp_type step_result;
   logic    fire;

   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   pptr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .result (step_result)
   );

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         out_data_ff <= step_result;
      end
   end

`ifndef NO_ASSERTIONS
   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("stepped request produced no response");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !fire) |=> in_valid_ff && $stable(in_data_ff))
      else $error("stalled request was lost");

   a_no_fire_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |-> !fire)
      else $error("response overwritten while stalled");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for parallel_port_ddr_transfer_slave.
// Drives request streams that emulate the host select clock and checks every response
// against a cycle-free model of the transfer logic; depends on pptr_pkg and the RTL top.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pptr_pkg::*;

   localparam logic [2:0] OP_SPARE_LO    = 3'd6;
   localparam logic [2:0] OP_SPARE_HI    = 3'd7;
   localparam int         RANDOM_ITEMS   = 400;
   localparam int         WATCHDOG_LIMIT = 5000;
   localparam int         DRAIN_CYCLES   = 20;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   parallel_port_ddr_transfer_slave uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Requests still to be sent, responses predicted but not yet seen.
   req_type backlog[$];
   rsp_type awaited_rsp[$];
   int      drain_points[$];
   int      total_items    = 0;
   int      launched       = 0;
   int      accepted_count = 0;
   int      errors         = 0;

   // Model copy of the transfer state.
   phase_type             ph       = PH_IDLE;
   logic                  want_q   = 1'b1;
   logic [LEFT_BITS-1:0]  left_q   = '0;
   logic [31:0]           shift_q  = '0;
   logic [2:0]            op_q     = '0;
   logic                  ready_q  = 1'b1;
   logic                  drive_q  = 1'b0;
   logic [7:0]            out_q    = '0;

   function automatic rsp_type port_step(req_type r);
      rsp_type              o;
      logic [LEFT_BITS-1:0] n;
      o = '0;
      o.command = IDLE_COMMAND;
      case (r.kind)
         KIND_LOWER: ready_q = 1'b0;
         KIND_START: begin
            if (ph == PH_IDLE && r.op <= OP_WR_BLOCK) begin
               op_q = r.op;
               ready_q = 1'b0;
               if (r.op <= OP_WR_WORD) n = 18'd2;
               else if (r.op <= OP_WR_LONG) n = 18'd4;
               else n = {1'b0, r.word_count, 1'b0};
               left_q = n;
               if (!r.op[0]) begin
                  // The value is left-aligned so that its top byte goes out first.
                  shift_q = (r.op == OP_RD_WORD) ? {r.load_value[15:0], 16'h0000}
                                                 : r.load_value;
                  ph = PH_WAIT_HI;
               end else begin
                  shift_q = '0;
                  want_q = 1'b1;
                  if (n == '0) begin
                     ph = PH_IDLE;
                     o.done_res = 1'b1;
                  end else begin
                     ph = PH_RECV;
                  end
               end
            end
         end
         KIND_END: begin
            if (ph == PH_IDLE || ph == PH_END_WAIT) begin
               if (r.select_level) begin
                  ready_q = 1'b1;
                  ph = PH_IDLE;
               end else begin
                  ph = PH_END_WAIT;
               end
            end
         end
         default: begin
            case (ph)
               PH_IDLE: if (!r.select_level) o.command = r.bus_in;
               PH_WAIT_HI: begin
                  if (r.select_level) begin
                     drive_q = 1'b1;
                     want_q = 1'b0;
                     ph = (left_q != '0) ? PH_SEND : PH_RELEASE;
                  end
               end
               PH_SEND: begin
                  if (r.select_level == want_q) begin
                     if (op_q == OP_RD_BLOCK) begin
                        out_q = r.next_byte;
                        o.byte_consumed = 1'b1;
                     end else begin
                        out_q = shift_q[31:24];
                        shift_q = shift_q << 8;
                     end
                     want_q = ~want_q;
                     left_q = left_q - 1'b1;
                     if (left_q == '0) ph = PH_RELEASE;
                  end
               end
               PH_RELEASE: begin
                  if (!r.select_level) begin
                     drive_q = 1'b0;
                     ph = PH_IDLE;
                     o.done_res = 1'b1;
                  end
               end
               PH_RECV: begin
                  if (r.select_level == want_q) begin
                     o.byte_captured = 1'b1;
                     o.captured_byte = r.bus_in;
                     shift_q = {shift_q[23:0], r.bus_in};
                     want_q = ~want_q;
                     left_q = left_q - 1'b1;
                     if (left_q == '0) begin
                        ph = PH_IDLE;
                        o.done_res = 1'b1;
                        if (op_q != OP_WR_BLOCK) o.word_result = shift_q;
                     end
                  end
               end
               PH_END_WAIT: begin
                  if (r.select_level) begin
                     ready_q = 1'b1;
                     ph = PH_IDLE;
                  end
               end
               default: ph = PH_IDLE;
            endcase
         end
      endcase
      o.ready_line   = ready_q;
      o.drive_enable = drive_q;
      o.bus_out      = out_q;
      return o;
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type noise_req();
      req_type r;
      r.kind         = 2'($urandom_range(0, 3));
      r.op           = 3'($urandom_range(0, 7));
      r.word_count   = 16'($urandom_range(0, 65535));
      r.load_value   = random_value();
      r.select_level = 1'($urandom_range(0, 1));
      r.bus_in       = 8'($urandom_range(0, 255));
      r.next_byte    = 8'($urandom_range(0, 255));
      return r;
   endfunction

   function automatic req_type shaped_req(logic [1:0] kind, logic sel);
      req_type r;
      r = noise_req();
      r.kind = kind;
      r.select_level = sel;
      return r;
   endfunction

   task automatic queue_start(logic [2:0] op, logic [15:0] count, logic [31:0] value);
      req_type r;
      r = shaped_req(KIND_START, 1'($urandom_range(0, 1)));
      r.op = op;
      r.word_count = count;
      r.load_value = value;
      backlog.push_back(r);
   endtask

   // One transfer as the host would run it: select toggles once per byte, with each level
   // held for one or more samples. The untidy form mixes in stray requests and an end.
   task automatic queue_transfer(logic [2:0] op, logic [15:0] count, logic [31:0] value,
                                 bit tidy);
      logic [1:0] busy_kinds[3];
      int         nbytes;
      int         levels;
      req_type    r;
      busy_kinds = '{KIND_START, KIND_END, KIND_LOWER};
      if (op <= OP_WR_WORD) nbytes = 2;
      else if (op <= OP_WR_LONG) nbytes = 4;
      else nbytes = 2 * count;
      levels = op[0] ? nbytes : nbytes + 2;
      if (!tidy) levels += $urandom_range(0, 2);
      queue_start(op, count, value);
      if (!tidy) repeat ($urandom_range(0, 2)) backlog.push_back(shaped_req(KIND_SAMPLE, 1'b0));
      for (int i = 0; i < levels; i++) begin
         repeat (tidy ? 1 : $urandom_range(1, 2)) begin
            backlog.push_back(shaped_req(KIND_SAMPLE, (i % 2) == 0));
            if (!tidy && $urandom_range(0, 19) == 0) begin
               r = noise_req();
               r.kind = busy_kinds[$urandom_range(0, 2)];
               backlog.push_back(r);
            end
         end
      end
      if (!tidy) begin
         backlog.push_back(shaped_req(KIND_END, 1'($urandom_range(0, 1))));
         repeat ($urandom_range(0, 2)) backlog.push_back(shaped_req(KIND_SAMPLE, 1'b0));
         backlog.push_back(shaped_req(KIND_SAMPLE, 1'b1));
         repeat ($urandom_range(0, 3)) backlog.push_back(shaped_req(KIND_SAMPLE, 1'b0));
      end
   endtask

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   // Driver: bursts of requests separated by random gaps.
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         ph = PH_IDLE;
         want_q = 1'b1;
         left_q = '0;
         shift_q = '0;
         op_q = '0;
         ready_q = 1'b1;
         drive_q = 1'b0;
         out_q = '0;
      end else begin
         if (req_valid && req_ready) begin
            accepted_count++;
            awaited_rsp.push_back(port_step(req_data));
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (backlog.size() == 0) begin
               req_valid <= 1'b0;
            end else if (drain_points.size() != 0 && launched == drain_points[0] &&
                         awaited_rsp.size() != 0) begin
               // Hold off until every outstanding response has come back.
               req_valid <= 1'b0;
            end else begin
               if (drain_points.size() != 0 && launched == drain_points[0])
                  void'(drain_points.pop_front());
               req_valid <= 1'b1;
               req_data <= backlog.pop_front();
               launched++;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // Monitor: checks each response and stalls the response channel in changing modes.
   logic [9:0] mon_cycle = '0;
   rsp_type    rsp_head;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         mon_cycle <= '0;
      end else begin
         mon_cycle <= mon_cycle + 1'b1;
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t: unexpected response expected none actual %h", $time, rsp_data);
               errors++;
            end else begin
               rsp_head = awaited_rsp.pop_front();
               check_field("ready_line", rsp_head.ready_line, rsp_data.ready_line);
               check_field("drive_enable", rsp_head.drive_enable, rsp_data.drive_enable);
               check_field("bus_out", rsp_head.bus_out, rsp_data.bus_out);
               check_field("byte_captured", rsp_head.byte_captured, rsp_data.byte_captured);
               check_field("captured_byte", rsp_head.captured_byte, rsp_data.captured_byte);
               check_field("byte_consumed", rsp_head.byte_consumed, rsp_data.byte_consumed);
               check_field("word_result", rsp_head.word_result, rsp_data.word_result);
               check_field("command", rsp_head.command, rsp_data.command);
               check_field("done_res", rsp_head.done_res, rsp_data.done_res);
            end
         end
         case (mon_cycle[9:8])
            2'd0: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= 1'($urandom_range(0, 1));
            2'd2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= (mon_cycle[3:0] < 4'd5);
         endcase
      end
   end

   // Watchdog: ends the run when neither channel has moved for too long.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no request or response accepted for %0d cycles", $time, idle_cycles);
         $display("** parallel_port_ddr_transfer_slave: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_type r;
      int      target;
      // Directed part: idle commands, a word read with stray requests while busy, word and
      // long writes, both empty blocks, unknown operations, ends and a lowered ready.
      r = shaped_req(KIND_SAMPLE, 1'b0);
      r.bus_in = 8'hff;
      backlog.push_back(r);
      r.bus_in = 8'h00;
      backlog.push_back(r);
      backlog.push_back(shaped_req(KIND_SAMPLE, 1'b1));
      queue_start(OP_RD_WORD, 16'hffff, 32'hffff_ffff);
      backlog.push_back(shaped_req(KIND_START, 1'b1));
      backlog.push_back(shaped_req(KIND_SAMPLE, 1'b1));
      backlog.push_back(shaped_req(KIND_SAMPLE, 1'b0));
      backlog.push_back(shaped_req(KIND_END, 1'b1));
      backlog.push_back(shaped_req(KIND_SAMPLE, 1'b1));
      backlog.push_back(shaped_req(KIND_SAMPLE, 1'b0));
      queue_transfer(OP_WR_WORD, 16'h0000, 32'h0000_0000, 1'b1);
      queue_transfer(OP_WR_LONG, 16'hffff, 32'hffff_ffff, 1'b1);
      queue_transfer(OP_WR_BLOCK, 16'h0000, 32'h0000_0000, 1'b1);
      queue_transfer(OP_RD_BLOCK, 16'h0000, 32'hffff_ffff, 1'b1);
      r = shaped_req(KIND_START, 1'b1);
      r.op = OP_SPARE_LO;
      backlog.push_back(r);
      r.op = OP_SPARE_HI;
      backlog.push_back(r);
      backlog.push_back(shaped_req(KIND_END, 1'b0));
      backlog.push_back(shaped_req(KIND_SAMPLE, 1'b1));
      backlog.push_back(shaped_req(KIND_LOWER, 1'b1));
      backlog.push_back(shaped_req(KIND_END, 1'b1));
      drain_points.push_back(backlog.size());

      // Random part: mostly well-formed transfers, with bursts of arbitrary requests.
      target = backlog.size() + RANDOM_ITEMS;
      drain_points.push_back(backlog.size() + RANDOM_ITEMS / 2);
      while (backlog.size() < target) begin
         if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 4)) backlog.push_back(noise_req());
         else
            queue_transfer(3'($urandom_range(OP_RD_WORD, OP_WR_BLOCK)),
                           16'(($urandom_range(0, 15) == 0) ? $urandom_range(4, 40)
                                                            : $urandom_range(0, 3)),
                           random_value(), 1'b0);
      end
      total_items = backlog.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (accepted_count < total_items || awaited_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("** parallel_port_ddr_transfer_slave: PASSED **");
      else
         $display("** parallel_port_ddr_transfer_slave: FAILED **");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/pptr_pkg.sv
hw/rtl/pptr_core.sv
hw/rtl/parallel_port_ddr_transfer_slave.sv
tb/tb.sv
